[sv/isl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package isl_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [3:0] OP_POP_FRONT  = 4'd2;
  localparam logic [3:0] OP_POP_BACK   = 4'd3;
  localparam logic [3:0] OP_INSERT     = 4'd4;
  localparam logic [3:0] OP_REMOVE     = 4'd5;
  localparam logic [3:0] OP_READ       = 4'd6;
  localparam logic [3:0] OP_CLEAR      = 4'd7;
  localparam logic [3:0] OP_ROTATE     = 4'd8;
  localparam logic [3:0] OP_SWAP       = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [3:0]               operation;
    logic signed [31:0]       value;
    logic [6:0]               position;
    logic [6:0]               shift_amount;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [31:0]       read_value;
    logic [6:0]               element_count;
  } out_t;

  typedef enum logic [2:0] {
    W_IN, W_VAL, W_RDATA, W_MAX_AT_MIN, W_MIN_AT_MAX
  } wsel_t;

  typedef struct packed {
    logic          load;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    wsel_t         wsel;
    logic [AW-1:0] waddr;
    logic          head_inc;
    logic          head_dec;
    logic          cnt_inc;
    logic          cnt_dec;
    logic          cnt_clr;
    logic          rd_cap;
    logic          scan_upd;
    logic          scan_first;
    logic [AW-1:0] scan_idx;
    logic          emit;
    logic [1:0]    status;
  } cmd_t;

endpackage
`default_nettype wire

[sv/isl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/isl_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module isl_datapath
  import isl_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cmd_t                         cmd,
  input  wire logic signed [DATA_WIDTH-1:0] in_value,
  output logic [CW-1:0]                     cnt,
  output logic                              out_valid,
  output out_t                              out_data
);

  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic signed [DATA_WIDTH-1:0] val_r, rd_r, min_r, max_r;
  logic [AW-1:0]                imin_r, imax_r;
  logic                         out_valid_r;
  out_t                         out_r;
  logic [DATA_WIDTH-1:0]        rdata, wdata;
  logic [AW-1:0]                wlog;
  logic signed [DATA_WIDTH-1:0] rs;

  assign rs = $signed(rdata);

  // write data and logical slot, made physical at the ram ports
  always_comb begin
    wlog  = cmd.waddr;
    wdata = val_r;
    case (cmd.wsel)
      W_IN:         wdata = in_value;
      W_VAL:        wdata = val_r;
      W_RDATA:      wdata = rdata;
      W_MAX_AT_MIN: begin
        wdata = max_r;
        wlog  = imin_r;
      end
      W_MIN_AT_MAX: begin
        wdata = min_r;
        wlog  = imax_r;
      end
      default:      wdata = val_r;
    endcase
  end

  isl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (head_r + wlog),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (head_r + cmd.rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    head_nxt = head_r;
    if (cmd.head_inc) begin
      head_nxt = head_r + AW'(1);
    end else if (cmd.head_dec) begin
      head_nxt = head_r - AW'(1);
    end
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value;
      rd_r  <= '0;
    end else if (cmd.rd_cap) begin
      rd_r <= rs;
    end
    if (cmd.scan_upd) begin
      if (cmd.scan_first) begin
        min_r  <= rs;
        max_r  <= rs;
        imin_r <= cmd.scan_idx;
        imax_r <= cmd.scan_idx;
      end else begin
        if (rs > max_r) begin
          max_r  <= rs;
          imax_r <= cmd.scan_idx;
        end
        if (rs < min_r) begin
          min_r  <= rs;
          imin_r <= cmd.scan_idx;
        end
      end
    end
    if (cmd.emit) begin
      out_r.status        <= cmd.status;
      out_r.read_value    <= rd_r;
      out_r.element_count <= cnt_r;
    end
  end

  assign cnt       = cnt_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[sv/isl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module isl_ctrl
  import isl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire in_t     in_data,
  input  wire logic [CW-1:0] cnt,
  output logic         busy,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_WR, S_REM_RD, S_REM_WR, S_RD_WAIT,
    S_ROT_RD, S_ROT_WR, S_SCAN, S_SW1, S_SW2, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] ri_r, ri_nxt;
  logic          pv_r, pv_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          full;

  assign full = (cnt >= CW'(DEPTH));

  always_comb begin
    cmd        = '0;
    cmd.wsel   = W_VAL;
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    ri_nxt     = ri_r;
    pv_nxt     = pv_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          pos_nxt    = in_data.position;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_data.operation)
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.we       = 1'b1;
                cmd.wsel     = W_IN;
                cmd.waddr    = '1;
                cmd.head_dec = 1'b1;
                cmd.cnt_inc  = 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.we      = 1'b1;
                cmd.wsel    = W_IN;
                cmd.waddr   = cnt[AW-1:0];
                cmd.cnt_inc = 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (cnt == '0) begin
                status_nxt = ST_RANGE;
              end else begin
                cmd.head_inc = 1'b1;
                cmd.cnt_dec  = 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (cnt == '0) begin
                status_nxt = ST_RANGE;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
            end
            OP_INSERT: begin
              if (in_data.position > cnt) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = cnt;
                state_nxt = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              if (in_data.position >= cnt) begin
                status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = in_data.position;
                state_nxt = S_REM_RD;
              end
            end
            OP_READ: begin
              if (in_data.position >= cnt) begin
                status_nxt = ST_RANGE;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = in_data.position[AW-1:0];
                state_nxt   = S_RD_WAIT;
              end
            end
            OP_CLEAR: begin
              cmd.cnt_clr = 1'b1;
            end
            OP_ROTATE: begin
              if (in_data.shift_amount > cnt) begin
                status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = in_data.shift_amount;
                state_nxt = S_ROT_RD;
              end
            end
            OP_SWAP: begin
              if (cnt < CW'(2)) begin
                status_nxt = ST_RANGE;
              end else begin
                ri_nxt    = '0;
                pv_nxt    = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: status_nxt = ST_RANGE;
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == pos_r) begin
          cmd.we      = 1'b1;
          cmd.wsel    = W_VAL;
          cmd.waddr   = pos_r[AW-1:0];
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r[AW-1:0] - AW'(1);
          state_nxt   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.we    = 1'b1;
        cmd.wsel  = W_RDATA;
        cmd.waddr = idx_r[AW-1:0];
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_INS_RD;
      end
      S_REM_RD: begin
        if ((idx_r + CW'(1)) >= cnt) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r[AW-1:0] + AW'(1);
          state_nxt   = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.we    = 1'b1;
        cmd.wsel  = W_RDATA;
        cmd.waddr = idx_r[AW-1:0];
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_REM_RD;
      end
      S_RD_WAIT: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_DONE;
      end
      S_ROT_RD: begin
        if (idx_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = '0;
          state_nxt   = S_ROT_WR;
        end
      end
      S_ROT_WR: begin
        // front entry goes to the slot just past the back, then front advances
        cmd.we       = 1'b1;
        cmd.wsel     = W_RDATA;
        cmd.waddr    = cnt[AW-1:0];
        cmd.head_inc = 1'b1;
        idx_nxt      = idx_r - CW'(1);
        state_nxt    = S_ROT_RD;
      end
      S_SCAN: begin
        if (ri_r < cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = ri_r[AW-1:0];
          ri_nxt      = ri_r + CW'(1);
        end
        pv_nxt = (ri_r < cnt);
        if (pv_r) begin
          cmd.scan_upd   = 1'b1;
          cmd.scan_idx   = ri_r[AW-1:0] - AW'(1);
          cmd.scan_first = (ri_r == CW'(1));
        end
        if (!pv_r && (ri_r >= cnt)) begin
          state_nxt = S_SW1;
        end
      end
      S_SW1: begin
        cmd.we    = 1'b1;
        cmd.wsel  = W_MAX_AT_MIN;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.we    = 1'b1;
        cmd.wsel  = W_MIN_AT_MAX;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        cmd.status = status_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      pos_r    <= '0;
      ri_r     <= '0;
      pv_r     <= 1'b0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      ri_r     <= ri_nxt;
      pv_r     <= pv_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[sv/indexed_sequence_list.sv]
// channel   | ports                        | transaction
// ----------+------------------------------+----------------------------------------
// input     | start, busy, in_data         | taken at a clock edge with start && !busy
// result    | out_valid, out_data          | one cycle strobe, receiver cannot stall
//
// insert and remove move each shifted entry with a read then a write;
//   rotate does the same per rotated entry; swap scans (one scan read a cycle)
// the store has one read port and one write port, each used once a cycle
// busy stays high from the accepting edge until the result strobe is scheduled
// reset clears the element count and front pointer; store contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module indexed_sequence_list
  import isl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire in_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_t      out_data
);

  // command bus from sequencer to datapath
  cmd_t          cmd;
  // element count back to the sequencer
  logic [CW-1:0] cnt;

  isl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .cnt     (cnt),
    .busy    (busy),
    .cmd     (cmd)
  );

  // circular store: front pointer plus count, so pushing or popping at either end moves no other entry
  isl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_data.value),
    .cnt       (cnt),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // an accepted transaction keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // results never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.element_count <= CW'(DEPTH)))
    else $error("element count beyond capacity");

  // a failed transaction (range or full) never reports a read value
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.read_value == '0))
    else $error("read value on failed transaction");
`endif

endmodule
`default_nettype wire
